@@ hdl/assert_macros.svh @@
// assertion macros used by the pose integrator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

@@ hdl/ddpi_pkg.sv @@
// shared types, constants and the cordic angle table of the pose integrator
`timescale 1ns / 1ps
`default_nettype none

package ddpi_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic [15:0]        STEP_TIME_RESET     = 16'd2621;
  localparam logic signed [31:0] START_X_RESET       = 32'sd0;
  localparam logic signed [31:0] START_Y_RESET       = 32'sd0;
  localparam logic [15:0]        START_HEADING_RESET = 16'd0;

  // start vector of the rotation, q2.30, pre-scaled by the inverse gain
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RESET   = 2'd1,
    OP_PAUSE   = 2'd2,
    OP_UNPAUSE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_STEP_TIME     = 2'd0,
    REG_START_X       = 2'd1,
    REG_START_Y       = 2'd2,
    REG_START_HEADING = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VDT,
    ST_ROT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_H,
    ST_ADD_H,
    ST_EMIT
  } state_e;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ hdl/diff_drive_pose_integrator_core.sv @@
// top level of the differential-drive dead-reckoning pose integrator
// usage:
//   input channel (in_valid_i / in_ready_o) takes one request per item:
//   tick, reset pose, pause or unpause. reset pose, pause, unpause and a
//   paused tick finish in the cycle they are accepted and give no result.
//   a tick that is not paused gives one pose on the output channel
//   (out_valid_o / out_ready_i). a tick right after a reset pose emits the
//   loaded pose with no cordic run; otherwise the tick takes v*dt, runs the
//   cordic loop of one iteration a cycle, then forms the x, y and heading
//   products on the single 32x32 multiplier, used four times in all.
//   in_ready_o is low while a tick is being worked on, so a new tick is
//   taken only once the last one is done.
//   the result sits in an output register; a stalled receiver holds it,
//   and a finished tick waits for that register to free up.
//   the user writes step_time and the start pose over apb only while idle;
//   the block does not enforce this. start values never reach the pose.
//   reset: async active low, the pose loads the start values' reset
//   values, pause and pending-reset marks clear, no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_pose_integrator_core import ddpi_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [15:0] speed_i,
  input  wire logic signed [23:0] turn_rate_i,
  input  wire logic signed [31:0] new_x_i,
  input  wire logic signed [31:0] new_y_i,
  input  wire logic [15:0]        new_heading_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      pose_x_o,
  output logic signed [31:0]      pose_y_o,
  output logic [15:0]             pose_heading_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic signed [63:0] RND_XY = 64'sd137438953472;
  localparam logic signed [63:0] RND_H  = 64'sd32768;

  state_e state_q, state_d;

  logic [15:0]        step_time_q;
  logic signed [31:0] start_x_q, start_y_q;
  logic [15:0]        start_heading_q;

  logic signed [31:0] x_q, y_q;
  logic [15:0]        h_q;
  logic               pending_q, paused_q;

  logic signed [15:0] speed_q;
  logic signed [23:0] turn_q;
  logic signed [31:0] vdt_q;
  logic signed [63:0] prod_q;

  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic [15:0]        out_h_q;

  logic               in_acc, cfg_wr, cordic_start, cordic_done, mul_en, emit;
  opcode_e            op;
  reg_idx_e           cfg_idx;
  logic signed [31:0] mul_a, mul_b, cos_v, sin_v;
  logic signed [63:0] prod, rnd_xy, rnd_h;

  assign op      = opcode_e'(opcode_i);
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign in_acc  = in_valid_i & in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q     <= STEP_TIME_RESET;
      start_x_q       <= START_X_RESET;
      start_y_q       <= START_Y_RESET;
      start_heading_q <= START_HEADING_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STEP_TIME:     step_time_q     <= pwdata[15:0];
        REG_START_X:       start_x_q       <= pwdata;
        REG_START_Y:       start_y_q       <= pwdata;
        REG_START_HEADING: start_heading_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STEP_TIME:     prdata = {16'b0, step_time_q};
      REG_START_X:       prdata = start_x_q;
      REG_START_Y:       prdata = start_y_q;
      REG_START_HEADING: prdata = {16'b0, start_heading_q};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && op == OP_TICK && !paused_q) begin
          state_d = pending_q ? ST_EMIT : ST_VDT;
        end
      end
      ST_VDT:   state_d = ST_ROT;
      ST_ROT:   if (cordic_done) state_d = ST_MUL_X;
      ST_MUL_X: state_d = ST_MUL_Y;
      ST_MUL_Y: state_d = ST_MUL_H;
      ST_MUL_H: state_d = ST_ADD_H;
      ST_ADD_H: state_d = ST_EMIT;
      ST_EMIT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs and multiplier operand select
  always_comb begin
    in_ready_o   = 1'b0;
    cordic_start = 1'b0;
    mul_en       = 1'b0;
    emit         = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cordic_start = in_acc && op == OP_TICK && !paused_q && !pending_q;
      end
      ST_VDT: begin
        mul_en = 1'b1;
        mul_a  = 32'(speed_q);
        mul_b  = {16'b0, step_time_q};
      end
      ST_MUL_X: begin
        mul_en = 1'b1;
        mul_a  = cos_v;
        mul_b  = vdt_q;
      end
      ST_MUL_Y: begin
        mul_en = 1'b1;
        mul_a  = sin_v;
        mul_b  = vdt_q;
      end
      ST_MUL_H: begin
        mul_en = 1'b1;
        mul_a  = 32'(turn_q);
        mul_b  = {16'b0, step_time_q};
      end
      ST_EMIT: emit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign rnd_xy = prod_q + RND_XY;
  assign rnd_h  = prod_q + RND_H;

  ddpi_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cordic_start),
    .heading_i(h_q),
    .done_o   (cordic_done),
    .cos_o    (cos_v),
    .sin_o    (sin_v)
  );

  // pose state and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= START_X_RESET;
      y_q         <= START_Y_RESET;
      h_q         <= START_HEADING_RESET;
      pending_q   <= 1'b0;
      paused_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        case (op)
          OP_RESET: begin
            x_q       <= new_x_i;
            y_q       <= new_y_i;
            h_q       <= new_heading_i;
            pending_q <= 1'b1;
          end
          OP_PAUSE:   paused_q <= 1'b1;
          OP_UNPAUSE: paused_q <= 1'b0;
          default:    if (!paused_q) pending_q <= 1'b0;
        endcase
      end
      // products arrive one state after their operands
      if (state_q == ST_MUL_Y) x_q <= x_q + 32'(rnd_xy >>> 38);
      if (state_q == ST_MUL_H) y_q <= y_q + 32'(rnd_xy >>> 38);
      if (state_q == ST_ADD_H) h_q <= h_q + rnd_h[31:16];
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      speed_q <= speed_i;
      turn_q  <= turn_rate_i;
    end
    if (mul_en) prod_q <= prod;
    if (state_q == ST_ROT) vdt_q <= prod_q[31:0];
    if (emit) begin
      out_x_q <= x_q;
      out_y_q <= y_q;
      out_h_q <= h_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pose_x_o       = out_x_q;
  assign pose_y_o       = out_y_q;
  assign pose_heading_o = out_h_q;

endmodule

`default_nettype wire

@@ hdl/ddpi_cordic.sv @@
// iterative rotation-mode cordic giving cos and sin of a binary-angle heading
`timescale 1ns / 1ps
`default_nettype none

module ddpi_cordic import ddpi_pkg::*; #(
  parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [15:0]        heading_i,
  output logic                    done_o,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);

  localparam int unsigned IW = $clog2(STEPS);
  localparam logic [IW-1:0] LAST = IW'(STEPS - 1);
  localparam logic signed [32:0] QUARTER = 33'sd1073741824;
  localparam logic signed [32:0] HALF    = 33'sd2147483648;

  logic signed [32:0] x_q, y_q, z_q;
  logic               neg_q;
  logic [IW-1:0]      cnt_q;
  logic               run_q, done_q;

  logic signed [32:0] z_raw, z_fold;
  logic               neg_fold;
  logic signed [32:0] dx, dy, at;

  // fold the angle into the right half plane, undo by negating the results
  always_comb begin
    z_raw    = {heading_i[15], heading_i, 16'b0};
    z_fold   = z_raw;
    neg_fold = 1'b0;
    if (z_raw > QUARTER) begin
      z_fold   = z_raw - HALF;
      neg_fold = 1'b1;
    end else if (z_raw < -QUARTER) begin
      z_fold   = z_raw + HALF;
      neg_fold = 1'b1;
    end
  end

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = {1'b0, atan_angle(5'(cnt_q))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CORDIC_X0;
      y_q   <= '0;
      z_q   <= z_fold;
      neg_q <= neg_fold;
    end else if (run_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = 32'(neg_q ? -x_q : x_q);
  assign sin_o  = 32'(neg_q ? -y_q : y_q);

endmodule

`default_nettype wire

@@ hdl/ddpi_checker.sv @@
// port-level checker of the pose integrator and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ddpi_checker import ddpi_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic [1:0]         opcode_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [31:0] pose_x_o,
  input wire logic signed [31:0] pose_y_o,
  input wire logic [15:0]        pose_heading_o,
  input wire logic               pready
);

  logic        in_acc, non_tick, out_stall;
  logic [79:0] pose_bus;

  assign in_acc    = in_valid_i & in_ready_o;
  assign non_tick  = opcode_e'(opcode_i) != OP_TICK;
  assign out_stall = out_valid_o & ~out_ready_i;
  assign pose_bus  = {pose_x_o, pose_y_o, pose_heading_o};

  `ASSERT_ANY(a_pready_high, clk_i, pready)

  // a stalled result keeps its pose
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(pose_bus))

  // requests other than a tick finish in the cycle they are taken
  `ASSERT_RST(a_non_tick_ready, clk_i, rst_ni, in_acc && non_tick |=> in_ready_o)

  // and they never produce a result
  `ASSERT_RST(a_non_tick_silent, clk_i, rst_ni, in_acc && non_tick |=> !$rose(out_valid_o))

endmodule

bind diff_drive_pose_integrator_core ddpi_checker u_ddpi_checker (.*);

`default_nettype wire
